// File: rtl/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types for the Miller-Rabin prime tester.
// ----------------------------------------------------------------------------
`default_nettype none
package mrpt_pkg;

    localparam int FIELD_W = 32;

    // Front-end classification of one item.
    typedef enum logic [1:0] {
        CLS_PASS = 2'd0,
        CLS_FAIL = 2'd1,
        CLS_SKIP = 2'd2,
        CLS_TEST = 2'd3
    } cls_t;

endpackage
`default_nettype wire

// File: rtl/mrpt_front.sv
// ----------------------------------------------------------------------------
// mrpt_front
// Classifies items and pushes them into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module mrpt_front #(
    parameter int W = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [mrpt_pkg::FIELD_W-1:0] in_cand,
    input  wire logic [mrpt_pkg::FIELD_W-1:0] in_wit,
    input  wire logic                         in_last,
    output logic                              q_valid,
    input  wire logic                         q_ready,
    output mrpt_pkg::cls_t                    q_cls,
    output logic [W-1:0]                      q_n,
    output logic [W-1:0]                      q_w,
    output logic                              q_last
);
    import mrpt_pkg::*;

    localparam int QW = 2 + 2 * W + 1;

    logic [W-1:0] n;
    logic [W-1:0] w;
    cls_t         cls;
    logic [QW-1:0] mem_reg [2];
    logic          wp_reg;
    logic          rp_reg;
    logic [1:0]    cnt_reg;
    logic          push;
    logic          pop;

    assign n = in_cand[W-1:0];
    assign w = in_wit[W-1:0];

    always_comb
    begin
        if (n <= W'(4))
            cls = (n == W'(2) || n == W'(3)) ? CLS_PASS : CLS_FAIL;
        else if (!n[0])
            cls = CLS_FAIL;
        else if (w < W'(2) || w > n - W'(2))
            cls = CLS_SKIP;
        else
            cls = CLS_TEST;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= {cls, n, w, in_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign q_cls  = cls_t'(mem_reg[rp_reg][QW-1 -: 2]);
    assign q_n    = mem_reg[rp_reg][2*W:W+1];
    assign q_w    = mem_reg[rp_reg][W:1];
    assign q_last = mem_reg[rp_reg][0];
endmodule
`default_nettype wire

// File: rtl/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt_mulmod
// Iterative a*b mod m: a multiply state (S_MUL), then restoring reduction one bit
// per cycle over the 2W-bit product.
// ----------------------------------------------------------------------------
`default_nettype none
module mrpt_mulmod #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W-1:0] m,
    output logic              done,
    output logic [W-1:0]      result
);
    localparam int CW = $clog2(2 * W + 1);

    typedef enum logic [1:0] { S_IDLE, S_MUL, S_RED } st_t;

    st_t             st_reg;
    logic [2*W-1:0]  prod_reg;
    logic [W-1:0]    m_reg;
    logic [W:0]      rem_reg;
    logic [CW-1:0]   cnt_reg;
    logic [W-1:0]    a_reg;
    logic [W-1:0]    b_reg;
    logic [W+1:0]    sh;
    logic [W+1:0]    diff;

    assign sh   = {rem_reg, prod_reg[2*W-1]};
    assign diff = sh - {2'b00, m_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            done   <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                        st_reg <= S_MUL;
                end
                S_MUL:
                    st_reg <= S_RED;
                S_RED:
                begin
                    if (cnt_reg == CW'(1))
                    begin
                        st_reg <= S_IDLE;
                        done   <= 1'b1;
                    end
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            begin
                a_reg <= a;
                b_reg <= b;
                m_reg <= m;
            end
            S_MUL:
            begin
                prod_reg <= a_reg * b_reg;
                rem_reg  <= '0;
                cnt_reg  <= CW'(2 * W);
            end
            S_RED:
            begin
                prod_reg <= {prod_reg[2*W-2:0], 1'b0};
                rem_reg  <= diff[W+1] ? sh[W:0] : diff[W:0];
                cnt_reg  <= cnt_reg - CW'(1);
            end
            default:
                cnt_reg <= cnt_reg;
        endcase
    end

    assign result = rem_reg[W-1:0];
endmodule
`default_nettype wire

// File: rtl/mrpt_back.sv
// ----------------------------------------------------------------------------
// mrpt_back
// Runs one Miller-Rabin round per queued CLS_TEST item and holds the run verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module mrpt_back #(
    parameter int W = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  mrpt_pkg::cls_t      q_cls,
    input  wire logic [W-1:0]   q_n,
    input  wire logic [W-1:0]   q_w,
    input  wire logic           q_last,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic                out_prime,
    output logic                out_skip
);
    import mrpt_pkg::*;

    localparam int RW = $clog2(W + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SPLIT, S_POW_SQ, S_POW_WAIT, S_SQR, S_SQR_WAIT, S_DONE
    } st_t;

    st_t          st_reg;
    logic [W-1:0] n_reg;
    logic [W-1:0] d_reg;
    logic [RW-1:0] r_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] sq_reg;
    logic         phase_reg;
    logic         last_reg;
    logic         verdict_reg;
    logic         skipped_reg;
    logic         pass_reg;
    logic         skip_item_reg;
    logic         mm_start;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic         mm_done;
    logic [W-1:0] mm_res;
    logic [W-1:0] nm1;
    logic         emit;

    assign nm1     = n_reg - W'(1);
    assign q_ready = (st_reg == S_IDLE);
    assign emit    = (st_reg == S_DONE) && last_reg && (!out_valid || out_ready);

    mrpt_mulmod #(.W(W)) u_mm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .a      (mm_a),
        .b      (mm_b),
        .m      (n_reg),
        .done   (mm_done),
        .result (mm_res)
    );

    always_comb
    begin
        mm_start = 1'b0;
        mm_a     = acc_reg;
        mm_b     = sq_reg;
        case (st_reg)
            S_POW_SQ:
            begin
                mm_start = 1'b1;
                if (phase_reg)
                    mm_a = sq_reg;
            end
            S_SQR:
            begin
                mm_start = 1'b1;
                mm_b     = acc_reg;
            end
            default:
                mm_start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            verdict_reg <= 1'b1;
            skipped_reg <= 1'b0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready && !emit)
                out_valid <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        n_reg    <= q_n;
                        d_reg    <= q_n - W'(1);
                        r_reg    <= '0;
                        acc_reg  <= W'(1);
                        sq_reg   <= q_w;
                        phase_reg <= 1'b0;
                        last_reg <= q_last;
                        skip_item_reg <= (q_cls == CLS_SKIP);
                        pass_reg <= (q_cls != CLS_FAIL);
                        st_reg   <= (q_cls == CLS_TEST) ? S_SPLIT : S_DONE;
                    end
                end
                S_SPLIT:
                begin
                    if (!d_reg[0])
                    begin
                        d_reg <= d_reg >> 1;
                        r_reg <= r_reg + RW'(1);
                    end
                    else
                        st_reg <= S_POW_SQ;
                end
                S_POW_SQ:
                    st_reg <= S_POW_WAIT;
                S_POW_WAIT:
                begin
                    if (mm_done)
                    begin
                        if (!phase_reg)
                        begin
                            if (d_reg[0])
                                acc_reg <= mm_res;
                            phase_reg <= 1'b1;
                            st_reg    <= S_POW_SQ;
                        end
                        else
                        begin
                            sq_reg    <= mm_res;
                            d_reg     <= d_reg >> 1;
                            phase_reg <= 1'b0;
                            if (d_reg == W'(1))
                            begin
                                if (acc_reg == W'(1) || acc_reg == nm1)
                                begin
                                    pass_reg <= 1'b1;
                                    st_reg   <= S_DONE;
                                end
                                else if (r_reg <= RW'(1))
                                begin
                                    pass_reg <= 1'b0;
                                    st_reg   <= S_DONE;
                                end
                                else
                                begin
                                    r_reg  <= r_reg - RW'(1);
                                    st_reg <= S_SQR;
                                end
                            end
                            else
                                st_reg <= S_POW_SQ;
                        end
                    end
                end
                S_SQR:
                    st_reg <= S_SQR_WAIT;
                S_SQR_WAIT:
                begin
                    if (mm_done)
                    begin
                        acc_reg <= mm_res;
                        if (mm_res == W'(1))
                        begin
                            pass_reg <= 1'b0;
                            st_reg   <= S_DONE;
                        end
                        else if (mm_res == nm1)
                        begin
                            pass_reg <= 1'b1;
                            st_reg   <= S_DONE;
                        end
                        else if (r_reg == RW'(1))
                        begin
                            pass_reg <= 1'b0;
                            st_reg   <= S_DONE;
                        end
                        else
                        begin
                            r_reg  <= r_reg - RW'(1);
                            st_reg <= S_SQR;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!last_reg)
                    begin
                        verdict_reg <= verdict_reg & pass_reg;
                        skipped_reg <= skipped_reg | skip_item_reg;
                        st_reg      <= S_IDLE;
                    end
                    else if (emit)
                    begin
                        out_valid   <= 1'b1;
                        out_prime   <= verdict_reg & pass_reg;
                        out_skip    <= skipped_reg | skip_item_reg;
                        verdict_reg <= 1'b1;
                        skipped_reg <= 1'b0;
                        st_reg      <= S_IDLE;
                    end
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/miller_rabin_prime_tester.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_tester
// Miller-Rabin primality rounds, one witness per item, verdict on last witness.
// ----------------------------------------------------------------------------
// Work: a tested witness needs up to about 2*NUM_WIDTH modular multiplies,
// all run one at a time in the shared bit-serial reducer.
// Flow: the back end holds one item at a time and takes the next only when idle.
// Reset: asynchronous, clears queue, control and run verdict.
`default_nettype none
module miller_rabin_prime_tester #(
    parameter int NUM_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [mrpt_pkg::FIELD_W-1:0] candidate,
    input  wire logic [mrpt_pkg::FIELD_W-1:0] witness,
    input  wire logic                         last_witness,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              probably_prime,
    output logic                              witness_skipped
);
    import mrpt_pkg::*;

    logic                 q_valid;
    logic                 q_ready;
    cls_t                 q_cls;
    logic [NUM_WIDTH-1:0] q_n;
    logic [NUM_WIDTH-1:0] q_w;
    logic                 q_last;

    mrpt_front #(.W(NUM_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_cand  (candidate),
        .in_wit   (witness),
        .in_last  (last_witness),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cls    (q_cls),
        .q_n      (q_n),
        .q_w      (q_w),
        .q_last   (q_last)
    );

    mrpt_back #(.W(NUM_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cls     (q_cls),
        .q_n       (q_n),
        .q_w       (q_w),
        .q_last    (q_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_prime (probably_prime),
        .out_skip  (witness_skipped)
    );
endmodule
`default_nettype wire
